### rtl/core/wsu_pkg.sv
package wsu_pkg;

  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_NEW   = 2'd3;

  localparam logic [2:0] SEL_CONN = 3'd0;
  localparam logic [2:0] SEL_UPG  = 3'd1;
  localparam logic [2:0] SEL_KEY  = 3'd2;
  localparam logic [2:0] SEL_VER  = 3'd3;
  localparam logic [2:0] SEL_NONE = 3'd4;

  localparam logic [4:0] NAME_POS_MAX = 5'd31;
  localparam logic [31:0] NUM_LIMIT = 32'd429496719;

  localparam logic [8*10-1:0] NAME_CONN = "connection";
  localparam logic [8*7-1:0]  NAME_UPG  = "upgrade";
  localparam logic [8*17-1:0] NAME_KEY  = "sec-websocket-key";
  localparam logic [8*21-1:0] NAME_VER  = "sec-websocket-version";
  localparam logic [8*9-1:0]  WORD_WS   = "websocket";
  localparam logic [8*7-1:0]  WORD_UP   = "upgrade";

  localparam logic [4:0] LEN_CONN = 5'd10;
  localparam logic [4:0] LEN_UPG  = 5'd7;
  localparam logic [4:0] LEN_KEY  = 5'd17;
  localparam logic [4:0] LEN_VER  = 5'd21;
  localparam logic [3:0] LEN_WS   = 4'd9;
  localparam logic [2:0] LEN_UP   = 3'd7;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic        websocket_req;
    logic        conn_has_upgrade;
    logic        version_valid;
    logic [31:0] version_number;
    logic        key_clear;
    logic        key_byte_valid;
    logic [7:0]  key_byte;
  } out_item_t;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] sel;
    logic       first;
    logic [7:0] ch;
  } op_t;

  function automatic logic [4:0] hdr_len(input logic [1:0] idx);
    logic [4:0] len;
    unique case (idx)
      2'd0:    len = LEN_CONN;
      2'd1:    len = LEN_UPG;
      2'd2:    len = LEN_KEY;
      default: len = LEN_VER;
    endcase
    return len;
  endfunction

  // Character at position pos of header name idx; pos must be below its length.
  function automatic logic [7:0] hdr_char(input logic [1:0] idx, input logic [4:0] pos);
    logic [7:0] c;
    c = 8'h00;
    unique case (idx)
      2'd0: if (pos < LEN_CONN) c = NAME_CONN[8*(int'(LEN_CONN) - 1 - int'(pos)) +: 8];
      2'd1: if (pos < LEN_UPG)  c = NAME_UPG[8*(int'(LEN_UPG) - 1 - int'(pos)) +: 8];
      2'd2: if (pos < LEN_KEY)  c = NAME_KEY[8*(int'(LEN_KEY) - 1 - int'(pos)) +: 8];
      default: if (pos < LEN_VER) c = NAME_VER[8*(int'(LEN_VER) - 1 - int'(pos)) +: 8];
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ws_char(input logic [3:0] pos);
    logic [7:0] c;
    c = 8'h00;
    if (pos < LEN_WS) c = WORD_WS[8*(int'(LEN_WS) - 1 - int'(pos)) +: 8];
    return c;
  endfunction

  function automatic logic [7:0] up_char(input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    if (pos < LEN_UP) c = WORD_UP[8*(int'(LEN_UP) - 1 - int'(pos)) +: 8];
    return c;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

### rtl/core/wsu_fifo.sv
module wsu_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

### rtl/core/wsu_front.sv
module wsu_front
  import wsu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     take,
  input  in_item_t item,
  output op_t      op
);

  logic [4:0] name_pos_r, name_pos_nxt;
  logic [3:0] cand_r, cand_nxt;
  logic       value_started_r, value_started_nxt;
  logic [2:0] sel;

  // Header lengths all differ, so at most one candidate can match the length.
  always_comb begin
    sel = SEL_NONE;
    for (int i = 3; i >= 0; i--) begin
      if (cand_r[i] && hdr_len(2'(i)) == name_pos_r) begin
        sel = 3'(i);
      end
    end
  end

  assign op.kind  = item.kind;
  assign op.ch    = item.ch;
  assign op.sel   = sel;
  assign op.first = !value_started_r;

  always_comb begin
    name_pos_nxt      = name_pos_r;
    cand_nxt          = cand_r;
    value_started_nxt = value_started_r;
    if (take) begin
      unique case (item.kind)
        KIND_NAME: begin
          if (!value_started_r) begin
            for (int i = 0; i < 4; i++) begin
              if (!(name_pos_r < hdr_len(2'(i)) && hdr_char(2'(i), name_pos_r) == item.ch)) begin
                cand_nxt[i] = 1'b0;
              end
            end
            if (name_pos_r != NAME_POS_MAX) begin
              name_pos_nxt = name_pos_r + 1'b1;
            end
          end
        end
        KIND_VALUE: begin
          value_started_nxt = 1'b1;
        end
        default: begin
          name_pos_nxt      = '0;
          cand_nxt          = 4'hF;
          value_started_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_pos_r      <= '0;
      cand_r          <= 4'hF;
      value_started_r <= 1'b0;
    end else begin
      name_pos_r      <= name_pos_nxt;
      cand_r          <= cand_nxt;
      value_started_r <= value_started_nxt;
    end
  end

endmodule

### rtl/core/wsu_back.sv
module wsu_back
  import wsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      op_valid,
  input  op_t       op,
  output logic      op_pop,
  input  logic      res_full,
  output logic      res_push,
  output out_item_t res
);

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_TOKEN,
    PH_TRAIL,
    PH_FAIL
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  tok_pos_r, tok_pos_nxt;
  logic [3:0]  word_pos_r, word_pos_nxt;
  logic        word_failed_r, word_failed_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        num_failed_r, num_failed_nxt;
  logic        ws_flag_r, ws_flag_nxt;
  logic        up_flag_r, up_flag_nxt;
  logic        ver_present_r, ver_present_nxt;
  logic [31:0] ver_value_r, ver_value_nxt;
  logic        fire;
  logic        token_hit;

  assign fire     = op_valid && !res_full;
  assign op_pop   = fire;
  assign res_push = fire;

  // A token counts if it spelled the whole word, with only whitespace after it.
  assign token_hit = (phase_r == PH_TOKEN || phase_r == PH_TRAIL) && tok_pos_r == LEN_UP;

  always_comb begin
    phase_nxt       = phase_r;
    tok_pos_nxt     = tok_pos_r;
    word_pos_nxt    = word_pos_r;
    word_failed_nxt = word_failed_r;
    acc_nxt         = acc_r;
    num_failed_nxt  = num_failed_r;
    ws_flag_nxt     = ws_flag_r;
    up_flag_nxt     = up_flag_r;
    ver_present_nxt = ver_present_r;
    ver_value_nxt   = ver_value_r;
    res.key_clear      = 1'b0;
    res.key_byte_valid = 1'b0;
    res.key_byte       = 8'h00;

    unique case (op.kind)
      KIND_NAME: begin
      end
      KIND_VALUE: begin
        unique case (op.sel)
          SEL_KEY: begin
            res.key_clear      = op.first;
            res.key_byte_valid = 1'b1;
            res.key_byte       = op.ch;
          end
          SEL_UPG: begin
            if (!word_failed_r) begin
              if (word_pos_r < LEN_WS && fold(op.ch) == ws_char(word_pos_r)) begin
                word_pos_nxt = word_pos_r + 1'b1;
              end else begin
                word_failed_nxt = 1'b1;
              end
            end
          end
          SEL_CONN: begin
            if (op.ch == 8'h2C) begin
              if (token_hit) up_flag_nxt = 1'b1;
              phase_nxt   = PH_LEAD;
              tok_pos_nxt = '0;
            end else if (is_ws(op.ch)) begin
              if (phase_r == PH_TOKEN) phase_nxt = PH_TRAIL;
            end else if (phase_r == PH_LEAD || phase_r == PH_TOKEN) begin
              if (tok_pos_r < LEN_UP && fold(op.ch) == up_char(tok_pos_r)) begin
                tok_pos_nxt = tok_pos_r + 1'b1;
                phase_nxt   = PH_TOKEN;
              end else begin
                phase_nxt = PH_FAIL;
              end
            end else begin
              phase_nxt = PH_FAIL;
            end
          end
          SEL_VER: begin
            if (!num_failed_r) begin
              if (op.ch < 8'h30 || op.ch > 8'h39 || acc_r > NUM_LIMIT) begin
                num_failed_nxt = 1'b1;
              end else begin
                acc_nxt = (acc_r << 3) + (acc_r << 1) + {28'd0, op.ch[3:0]};
              end
            end
          end
          default: begin
          end
        endcase
      end
      KIND_END: begin
        unique case (op.sel)
          SEL_KEY: res.key_clear = op.first;
          SEL_UPG: begin
            if (!word_failed_r && word_pos_r == LEN_WS) ws_flag_nxt = 1'b1;
          end
          SEL_CONN: begin
            if (token_hit) up_flag_nxt = 1'b1;
          end
          SEL_VER: begin
            ver_present_nxt = !num_failed_r;
            ver_value_nxt   = num_failed_r ? 32'd0 : acc_r;
          end
          default: begin
          end
        endcase
        phase_nxt       = PH_LEAD;
        tok_pos_nxt     = '0;
        word_pos_nxt    = '0;
        word_failed_nxt = 1'b0;
        acc_nxt         = '0;
        num_failed_nxt  = 1'b0;
      end
      default: begin
        phase_nxt       = PH_LEAD;
        tok_pos_nxt     = '0;
        word_pos_nxt    = '0;
        word_failed_nxt = 1'b0;
        acc_nxt         = '0;
        num_failed_nxt  = 1'b0;
        ws_flag_nxt     = 1'b0;
        up_flag_nxt     = 1'b0;
        ver_present_nxt = 1'b0;
        ver_value_nxt   = '0;
        res.key_clear   = 1'b1;
      end
    endcase

    res.websocket_req    = ws_flag_nxt;
    res.conn_has_upgrade = up_flag_nxt;
    res.version_valid    = ver_present_nxt;
    res.version_number   = ver_present_nxt ? ver_value_nxt : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_LEAD;
      tok_pos_r     <= '0;
      word_pos_r    <= '0;
      word_failed_r <= 1'b0;
      acc_r         <= '0;
      num_failed_r  <= 1'b0;
      ws_flag_r     <= 1'b0;
      up_flag_r     <= 1'b0;
      ver_present_r <= 1'b0;
      ver_value_r   <= '0;
    end else if (fire) begin
      phase_r       <= phase_nxt;
      tok_pos_r     <= tok_pos_nxt;
      word_pos_r    <= word_pos_nxt;
      word_failed_r <= word_failed_nxt;
      acc_r         <= acc_nxt;
      num_failed_r  <= num_failed_nxt;
      ws_flag_r     <= ws_flag_nxt;
      up_flag_r     <= up_flag_nxt;
      ver_present_r <= ver_present_nxt;
      ver_value_r   <= ver_value_nxt;
    end
  end

endmodule

### rtl/core/websocket_upgrade_header_scanner.sv
// Scans HTTP header lines byte by byte for a WebSocket upgrade request and
// returns one result for every item pushed, in order. The front end matches
// header names and tags each byte with the header it belongs to; the tagged
// bytes wait in a small queue for the back end, which runs the value checks,
// the version number and the sticky flags, and writes one result into the
// result queue. One item is taken every cycle at full rate while the op
// queue has room. A result passes through the op queue and then the result
// queue, each adding a register, before it can be read. Each side stalls on
// its own as long as the queues have room. The flags are kept until a
// new-request item clears them; the version is replaced at the end of each
// version header and is cleared by a new-request item too.
module websocket_upgrade_header_scanner
  import wsu_pkg::*;
#(
  parameter int OP_DEPTH  = 2,
  parameter int OUT_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  localparam int OP_W  = $bits(op_t);
  localparam int OUT_W = $bits(out_item_t);

  op_t       front_op;
  op_t       back_op;
  logic      op_empty;
  logic      op_pop;
  logic      res_full;
  logic      res_push;
  out_item_t res;
  logic      take;

  assign take = push && !full;

  wsu_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (in_item),
    .op    (front_op)
  );

  wsu_fifo #(
    .W     (OP_W),
    .DEPTH (OP_DEPTH)
  ) u_op_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (front_op),
    .full  (full),
    .pop   (op_pop),
    .rdata (back_op),
    .empty (op_empty)
  );

  wsu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (!op_empty),
    .op       (back_op),
    .op_pop   (op_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  wsu_fifo #(
    .W     (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_item),
    .empty (empty)
  );

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> !op_empty)
    else $error("accepted item did not reach the op queue");

  a_key_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_item.key_byte_valid |-> out_item.key_byte == 8'h00)
    else $error("key byte not zero without a key transfer");

  a_version_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_item.version_valid |-> out_item.version_number == 32'd0)
    else $error("version number not zero while version is absent");

  a_key_bits: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res.key_byte_valid |-> back_op.kind == KIND_VALUE && back_op.sel == SEL_KEY)
    else $error("key byte produced outside a key value byte");

endmodule
